// File: hw/rtl/connection_reorder_prefetch_gate_unit_macros.svh
// Assertion macros shared by the reorder gate RTL
`ifndef CONNECTION_REORDER_PREFETCH_GATE_UNIT_MACROS_SVH
`define CONNECTION_REORDER_PREFETCH_GATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CRPG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crpg assertion failed");

// Next-cycle implication, disabled during reset
`define CRPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crpg assertion failed");

`endif

// File: hw/rtl/crpg_pkg.sv
// Types, codes and defaults for the connection reorder prefetch gate
package crpg_pkg;

    localparam int DEF_HOST_COUNT     = 4;
    localparam int DEF_CONNS_PER_HOST = 64;
    localparam int DEF_QUEUE_DEPTH    = 16;
    localparam int MAX_RESULTS        = 16;
    localparam int ENTRY_W            = 53;
    localparam logic [23:0] CAP_RESET = 24'd65536;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_ENQUEUE = 3'd1,
        OP_QUERY   = 3'd2,
        OP_REFUND  = 3'd3,
        OP_FETCH   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_UNDERFLOW = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_READ,
        S_LAST
    } t_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  host_id;
        logic [5:0]  connection_id;
        logic [31:0] seq_number;
        logic [3:0]  packet_kind;
        logic        in_dram;
        logic        ordered;
        logic [15:0] byte_count;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic        fits;
        logic [5:0]  release_connection;
        logic [31:0] release_seq;
        logic [3:0]  release_kind;
        logic        last;
    } t_out_item;

endpackage

// File: hw/rtl/crpg_ram.sv
// Generic single-write, single-read RAM with registered read data
module crpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/connection_reorder_prefetch_gate_unit.sv
// Top level of the connection reorder prefetch gate
// Takes one command per transfer when i_start is high and o_busy low. Init, enqueue,
// space query and refund pass through the accept cycle and the S_META state, which
// sees the queue metadata RAM read, and give one result in the cycle after. A fetch
// completion that releases k entries spends one S_READ state per released entry, each
// reading the entry RAM, whose registered read paces the drain, plus an S_LAST or stop
// state that sees the stop condition. Results are strobed on o_strobe for one cycle each
// and cannot be held off; o_result.last marks the final result of a command. Op codes
// 5 to 7 give no result. Connection valid bits are flip-flops cleared by reset, so no
// clearing pass is needed.
module connection_reorder_prefetch_gate_unit
    import crpg_pkg::*;
#(
    parameter int HOST_COUNT     = DEF_HOST_COUNT,
    parameter int CONNS_PER_HOST = DEF_CONNS_PER_HOST,
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data,
    output logic        o_strobe,
    output t_out_item   o_result
);

`include "connection_reorder_prefetch_gate_unit_macros.svh"

    localparam int NQ    = HOST_COUNT * CONNS_PER_HOST;
    localparam int HW    = (HOST_COUNT > 1) ? $clog2(HOST_COUNT) : 1;
    localparam int CW    = (CONNS_PER_HOST > 1) ? $clog2(CONNS_PER_HOST) : 1;
    localparam int QW    = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int SW    = $clog2(QUEUE_DEPTH);
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NE    = NQ * QUEUE_DEPTH;
    localparam int EAW   = $clog2(NE);
    localparam int MW    = SW + CNTW;
    localparam int NW    = $clog2(MAX_RESULTS + 1);

    // Registers
    t_state              r_state, n_state;
    t_in_item            r_item;
    logic [HW-1:0]       r_host;
    logic [QW-1:0]       r_q;
    logic                r_qvalid;
    logic [SW-1:0]       r_head, n_head;
    logic [CNTW-1:0]     r_count, n_count;
    logic [NW-1:0]       r_n, n_n;
    logic [31:0]         r_pend_seq, n_pend_seq;
    logic [3:0]          r_pend_kind, n_pend_kind;
    t_out_item           r_out, n_out;
    logic                r_strobe, n_strobe;
    logic [23:0]         r_cap;
    logic [23:0]         r_occ [HOST_COUNT];
    logic [23:0]         n_occ_val;
    logic                n_occ_we;
    logic                r_conn_valid [NQ];
    logic                n_set_valid;

    // Index wrap tables and queue index
    logic [HW-1:0]       w_host_map [4];
    logic [CW-1:0]       w_conn_map [64];
    logic [HW-1:0]       w_host;
    logic [CW-1:0]       w_conn;
    logic [QW-1:0]       w_q;
    logic                w_accept;

    for (genvar g = 0; g < 4; g++) begin : g_host_map
        assign w_host_map[g] = HW'(g % HOST_COUNT);
    end
    for (genvar g = 0; g < 64; g++) begin : g_conn_map
        assign w_conn_map[g] = CW'(g % CONNS_PER_HOST);
    end

    assign w_host   = w_host_map[i_item.host_id];
    assign w_conn   = w_conn_map[i_item.connection_id];
    assign w_q      = QW'(QW'(w_host) * QW'(CONNS_PER_HOST)) + QW'(w_conn);
    assign w_accept = i_start && (r_state == S_IDLE);

    // Memories
    logic                meta_we;
    logic [MW-1:0]       meta_wdata, meta_rdata;
    logic                ent_we;
    logic [EAW-1:0]      ent_waddr, ent_raddr;
    logic [ENTRY_W-1:0]  ent_wdata, ent_rdata;

    crpg_ram #(.WIDTH(MW), .DEPTH(NQ)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_q),
        .i_wdata (meta_wdata),
        .i_raddr (w_q),
        .o_rdata (meta_rdata)
    );

    crpg_ram #(.WIDTH(ENTRY_W), .DEPTH(NE)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // Decoded metadata: an invalid connection reads as an empty queue at slot zero
    logic [SW-1:0]       m_head;
    logic [CNTW-1:0]     m_count;
    logic [24:0]         w_sum;
    logic                w_fits;
    logic [SW:0]         w_slot_sum;
    logic [SW-1:0]       w_tail;
    logic [SW-1:0]       w_head_inc;
    logic                w_e_dram;
    logic                w_first;
    logic [CNTW-1:0]     w_cnt_dec;
    logic [NW-1:0]       w_n_inc;

    assign m_head     = r_qvalid ? meta_rdata[MW-1:CNTW] : '0;
    assign m_count    = r_qvalid ? meta_rdata[CNTW-1:0] : '0;
    assign w_sum      = {1'b0, r_occ[r_host]} + 25'(r_item.byte_count);
    assign w_fits     = (w_sum <= {1'b0, r_cap});
    assign w_slot_sum = (SW+1)'(m_head) + (SW+1)'(m_count);
    assign w_tail     = (w_slot_sum >= (SW+1)'(QUEUE_DEPTH)) ?
                        SW'(w_slot_sum - (SW+1)'(QUEUE_DEPTH)) : SW'(w_slot_sum);
    assign w_head_inc = ((SW+1)'(r_head) + (SW+1)'(1) == (SW+1)'(QUEUE_DEPTH)) ?
                        '0 : r_head + SW'(1);
    assign w_e_dram   = ent_rdata[36];
    assign w_first    = (r_n == '0);
    assign w_cnt_dec  = r_count - CNTW'(1);
    assign w_n_inc    = r_n + NW'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_META;
                end
            end
            S_META: begin
                if (r_item.op == OP_FETCH && m_count != '0) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (!w_first && w_e_dram) begin
                    n_state = S_IDLE;
                end else if (w_cnt_dec == '0 || w_n_inc >= NW'(MAX_RESULTS)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and results
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_n         = r_n;
        n_pend_seq  = r_pend_seq;
        n_pend_kind = r_pend_kind;
        n_out       = '0;
        n_strobe    = 1'b0;
        n_occ_we    = 1'b0;
        n_occ_val   = r_occ[r_host];
        n_set_valid = 1'b0;
        meta_we     = 1'b0;
        meta_wdata  = {r_head, r_count};
        ent_we      = 1'b0;
        ent_waddr   = EAW'(EAW'(r_q) * EAW'(QUEUE_DEPTH)) + EAW'(w_tail);
        ent_wdata   = {r_item.byte_count, r_item.in_dram, r_item.packet_kind,
                       r_item.seq_number};
        ent_raddr   = EAW'(EAW'(r_q) * EAW'(QUEUE_DEPTH)) + EAW'(m_head);
        unique case (r_state)
            S_IDLE: begin
            end
            S_META: begin
                n_out.last = 1'b1;
                case (r_item.op)
                    OP_INIT: begin
                        n_strobe = 1'b1;
                        if (r_qvalid) begin
                            n_out.status = ST_EXISTS;
                        end else begin
                            n_set_valid = 1'b1;
                            meta_we     = 1'b1;
                            meta_wdata  = '0;
                        end
                    end
                    OP_ENQUEUE: begin
                        // Keep metadata coherent when the connection becomes valid
                        n_strobe    = 1'b1;
                        n_set_valid = 1'b1;
                        meta_we     = 1'b1;
                        meta_wdata  = {m_head, m_count};
                        if (r_item.in_dram || (r_item.ordered && m_count != '0)) begin
                            if (!w_fits) begin
                                n_out.status = ST_OVERFLOW;
                            end else if (m_count >= CNTW'(QUEUE_DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                ent_we     = 1'b1;
                                meta_wdata = {m_head, m_count + CNTW'(1)};
                                n_occ_we   = 1'b1;
                                n_occ_val  = w_sum[23:0];
                            end
                        end else begin
                            n_out.kind               = 1'b1;
                            n_out.release_connection = r_item.connection_id;
                            n_out.release_seq        = r_item.seq_number;
                            n_out.release_kind       = r_item.packet_kind;
                        end
                    end
                    OP_QUERY: begin
                        n_strobe   = 1'b1;
                        n_out.fits = w_fits;
                    end
                    OP_REFUND: begin
                        n_strobe = 1'b1;
                        n_occ_we = 1'b1;
                        if (24'(r_item.byte_count) > r_occ[r_host]) begin
                            n_occ_val    = '0;
                            n_out.status = ST_UNDERFLOW;
                        end else begin
                            n_occ_val = r_occ[r_host] - 24'(r_item.byte_count);
                        end
                    end
                    OP_FETCH: begin
                        if (m_count == '0) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_head  = m_head;
                            n_count = m_count;
                            n_n     = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                n_out.kind               = 1'b1;
                n_out.release_connection = r_item.connection_id;
                n_out.release_seq        = r_pend_seq;
                n_out.release_kind       = r_pend_kind;
                if (!w_first && w_e_dram) begin
                    // Stop at the next DRAM entry and flush the held release
                    n_strobe    = 1'b1;
                    n_out.last  = 1'b1;
                    meta_we     = 1'b1;
                end else begin
                    // Consume this entry, emit the one held before it
                    n_strobe    = !w_first;
                    n_pend_seq  = ent_rdata[31:0];
                    n_pend_kind = ent_rdata[35:32];
                    n_head      = w_head_inc;
                    n_count     = w_cnt_dec;
                    n_n         = w_n_inc;
                    ent_raddr   = EAW'(EAW'(r_q) * EAW'(QUEUE_DEPTH)) + EAW'(w_head_inc);
                end
            end
            S_LAST: begin
                n_strobe                 = 1'b1;
                n_out.kind               = 1'b1;
                n_out.release_connection = r_item.connection_id;
                n_out.release_seq        = r_pend_seq;
                n_out.release_kind       = r_pend_kind;
                n_out.last               = 1'b1;
                meta_we                  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_cap    <= CAP_RESET;
            for (int i = 0; i < HOST_COUNT; i++) begin
                r_occ[i] <= '0;
            end
            for (int i = 0; i < NQ; i++) begin
                r_conn_valid[i] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (n_occ_we) begin
                r_occ[r_host] <= n_occ_val;
            end
            if (n_set_valid) begin
                r_conn_valid[r_q] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item   <= i_item;
            r_host   <= w_host;
            r_q      <= w_q;
            r_qvalid <= r_conn_valid[w_q];
        end
        r_head      <= n_head;
        r_count     <= n_count;
        r_n         <= n_n;
        r_pend_seq  <= n_pend_seq;
        r_pend_kind <= n_pend_kind;
        r_out       <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Checks
    `CRPG_ASSERT_NEXT(a_accept_reads_meta, w_accept, r_state == S_META)
    `CRPG_ASSERT_IMPL(a_partial_drain_busy, o_strobe && !o_result.last, r_state != S_IDLE)
    `CRPG_ASSERT_IMPL(a_drain_count_bound, r_state == S_READ || r_state == S_LAST,
                      r_count <= CNTW'(QUEUE_DEPTH) && r_n <= NW'(MAX_RESULTS))
    `CRPG_ASSERT_NEXT(a_result_after_work, n_strobe, o_strobe)

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the connection reorder prefetch gate
module testbench
    import crpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_HOSTS  = 4;
    localparam int N_CONNS  = 64;
    localparam int Q_DEPTH  = 16;
    localparam int N_QUEUES = N_HOSTS * N_CONNS;

    // Reference gate state plus the queue of expected results
    class gate_scoreboard;
        logic [23:0] capacity;
        logic [23:0] occupied [N_HOSTS];
        bit          conn_ok  [N_QUEUES];
        int          head     [N_QUEUES];
        int          count    [N_QUEUES];
        logic [52:0] entries  [N_QUEUES][Q_DEPTH];
        t_out_item   pending_results[$];
        int          errors;

        function new();
            capacity = CAP_RESET;
            for (int h = 0; h < N_HOSTS; h++) occupied[h] = '0;
            for (int q = 0; q < N_QUEUES; q++) begin
                conn_ok[q] = 0;
                head[q] = 0;
                count[q] = 0;
            end
            errors = 0;
        endfunction

        function void push_status(logic [2:0] st, logic fit);
            t_out_item r;
            r = '0;
            r.status = st;
            r.fits = fit;
            r.last = 1'b1;
            pending_results.push_back(r);
        endfunction

        function void push_release(logic [5:0] c, logic [31:0] s, logic [3:0] k, logic l);
            t_out_item r;
            r = '0;
            r.kind = 1'b1;
            r.release_connection = c;
            r.release_seq = s;
            r.release_kind = k;
            r.last = l;
            pending_results.push_back(r);
        endfunction

        // Predict the results of one accepted command
        function void note_command(t_in_item it);
            int q, h, n, slot;
            logic [24:0] sum;
            logic [52:0] e;
            h = it.host_id;
            q = h * N_CONNS + it.connection_id;
            sum = occupied[h] + it.byte_count;
            case (it.op)
                OP_INIT: begin
                    if (conn_ok[q]) begin
                        push_status(ST_EXISTS, 0);
                    end else begin
                        conn_ok[q] = 1;
                        head[q] = 0;
                        count[q] = 0;
                        push_status(ST_OK, 0);
                    end
                end
                OP_ENQUEUE: begin
                    conn_ok[q] = 1;
                    if (it.in_dram || (it.ordered && count[q] != 0)) begin
                        if (sum > capacity) begin
                            push_status(ST_OVERFLOW, 0);
                        end else if (count[q] >= Q_DEPTH) begin
                            push_status(ST_FULL, 0);
                        end else begin
                            slot = (head[q] + count[q]) % Q_DEPTH;
                            entries[q][slot] = {it.byte_count, it.in_dram,
                                                it.packet_kind, it.seq_number};
                            count[q]++;
                            occupied[h] = sum[23:0];
                            push_status(ST_OK, 0);
                        end
                    end else begin
                        push_release(it.connection_id, it.seq_number, it.packet_kind, 1);
                    end
                end
                OP_QUERY: push_status(ST_OK, sum <= capacity);
                OP_REFUND: begin
                    if (it.byte_count > occupied[h]) begin
                        occupied[h] = '0;
                        push_status(ST_UNDERFLOW, 0);
                    end else begin
                        occupied[h] = occupied[h] - it.byte_count;
                        push_status(ST_OK, 0);
                    end
                end
                OP_FETCH: begin
                    if (count[q] == 0) begin
                        push_status(ST_EMPTY, 0);
                    end else begin
                        n = 0;
                        // Release the head, then drain SRAM entries up to the next DRAM one
                        do begin
                            e = entries[q][head[q]];
                            head[q] = (head[q] + 1) % Q_DEPTH;
                            count[q]--;
                            n++;
                            push_release(it.connection_id, e[31:0], e[35:32],
                                (n >= MAX_RESULTS || count[q] == 0 || entries[q][head[q]][36]));
                        end while (n < MAX_RESULTS && count[q] != 0 && !entries[q][head[q]][36]);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            exp = pending_results.pop_front();
            if (got.kind !== exp.kind) report_mismatch("kind");
            if (got.status !== exp.status) report_mismatch("status");
            if (got.fits !== exp.fits) report_mismatch("fits");
            if (got.release_connection !== exp.release_connection)
                report_mismatch("release_connection");
            if (got.release_seq !== exp.release_seq) report_mismatch("release_seq");
            if (got.release_kind !== exp.release_kind) report_mismatch("release_kind");
            if (got.last !== exp.last) report_mismatch("last");
        endfunction

        function void report_mismatch(string what);
            errors++;
            if (errors <= 40) $display("mismatch at %0t: %s", $realtime, what);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_in_item    i_item;
    logic        o_busy;
    logic        i_cfg_we;
    logic [23:0] i_cfg_data;
    logic        o_strobe;
    t_out_item   o_result;

    gate_scoreboard sb;
    bit             done_flag;

    connection_reorder_prefetch_gate_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_item     (i_item),
        .o_busy     (o_busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Check every strobed result at the edge that takes it
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    // Mostly the shortest gap, some short ones, a few long ones
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 50) n = 1;
        else if (r < 92) n = $urandom_range(2, 4);
        else n = $urandom_range(9, 31);
        repeat (n) @(negedge i_clk);
    endtask

    // Present one command and hold it until the block takes the transfer
    task automatic send_command(t_in_item it);
        i_item <= it;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_command(it);
        @(negedge i_clk);
        i_start <= 1'b0;
        idle_gap();
    endtask

    // Wait for all expected results, then let an op that gives none settle
    task automatic drain_results();
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [23:0] v);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.capacity = v;
    endtask

    function automatic t_in_item make_cmd(logic [2:0] op, logic [1:0] h, logic [5:0] c,
                                          logic dram, logic ord, logic [15:0] b);
        t_in_item it;
        it.op = op;
        it.host_id = h;
        it.connection_id = c;
        it.seq_number = $urandom();
        it.packet_kind = 4'($urandom_range(0, 15));
        it.in_dram = dram;
        it.ordered = ord;
        it.byte_count = b;
        return it;
    endfunction

    // A random command biased toward a few busy connections
    function automatic t_in_item random_cmd();
        int r;
        logic [2:0] op;
        logic [15:0] b;
        r = $urandom_range(0, 99);
        if (r < 8) op = OP_INIT;
        else if (r < 60) op = OP_ENQUEUE;
        else if (r < 68) op = OP_QUERY;
        else if (r < 80) op = OP_REFUND;
        else if (r < 97) op = OP_FETCH;
        else op = 3'($urandom_range(5, 7));
        r = $urandom_range(0, 9);
        b = (r == 0) ? 16'hFFFF : (r < 3) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
        return make_cmd(op, 2'($urandom_range(0, 3)),
                        ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 3)),
                        $urandom_range(0, 2) == 0, $urandom_range(0, 3) != 0, b);
    endfunction

    initial begin
        t_in_item it;
        sb = new();
        done_flag = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: init and duplicate init
        send_command(make_cmd(OP_INIT, 0, 0, 0, 1, 0));
        send_command(make_cmd(OP_INIT, 0, 0, 0, 1, 0));
        // Fetch on an empty and on a never-initialized queue
        send_command(make_cmd(OP_FETCH, 0, 0, 0, 0, 0));
        send_command(make_cmd(OP_FETCH, 3, 63, 0, 0, 0));
        // Implicit init by enqueue, then init reports exists
        send_command(make_cmd(OP_ENQUEUE, 3, 63, 0, 0, 16'hFFFF));
        send_command(make_cmd(OP_INIT, 3, 63, 0, 0, 0));
        // Ordered queue: DRAM head, SRAM followers, DRAM stop
        send_command(make_cmd(OP_ENQUEUE, 1, 5, 1, 1, 100));
        send_command(make_cmd(OP_ENQUEUE, 1, 5, 0, 1, 200));
        send_command(make_cmd(OP_ENQUEUE, 1, 5, 0, 1, 300));
        send_command(make_cmd(OP_ENQUEUE, 1, 5, 1, 1, 400));
        send_command(make_cmd(OP_ENQUEUE, 1, 5, 0, 0, 50));
        send_command(make_cmd(OP_FETCH, 1, 5, 0, 0, 0));
        send_command(make_cmd(OP_FETCH, 1, 5, 0, 0, 0));
        // Query and overflow at the limit
        send_command(make_cmd(OP_QUERY, 1, 0, 0, 0, 16'hFFFF));
        send_command(make_cmd(OP_ENQUEUE, 1, 6, 1, 0, 16'hFFFF));
        send_command(make_cmd(OP_QUERY, 1, 0, 0, 0, 0));
        // Refund with underflow, exact, and op codes that give no result
        send_command(make_cmd(OP_REFUND, 1, 0, 0, 0, 16'hFFFF));
        send_command(make_cmd(OP_REFUND, 1, 0, 0, 0, 0));
        send_command(make_cmd(3'd5, 2, 0, 0, 0, 0));
        send_command(make_cmd(3'd7, 2, 0, 1, 1, 16'hFFFF));
        drain_results();

        // Full queue then a drain of all MAX_RESULTS entries, then a fetch on the emptied queue
        write_capacity(24'hFFFFFF);
        send_command(make_cmd(OP_ENQUEUE, 2, 9, 1, 1, 10));
        for (int i = 0; i < 16; i++) send_command(make_cmd(OP_ENQUEUE, 2, 9, 0, 1, 10));
        send_command(make_cmd(OP_FETCH, 2, 9, 0, 0, 0));
        send_command(make_cmd(OP_FETCH, 2, 9, 0, 0, 0));
        drain_results();

        // Random phases at several capacities, extremes among them
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_capacity(24'd0);
                1: write_capacity(24'd20000);
                2: write_capacity(24'hFFFFFF);
                default: write_capacity(CAP_RESET);
            endcase
            for (int i = 0; i < 100; i++) begin
                it = random_cmd();
                send_command(it);
                if (i == 50) while (sb.pending_results.size() != 0) @(negedge i_clk);
            end
            drain_results();
        end

        done_flag = 1;
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        if (!done_flag) $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/crpg_pkg.sv
hw/rtl/crpg_ram.sv
hw/rtl/connection_reorder_prefetch_gate_unit.sv
verif/testbench.sv
